// ===== rtl/ttl_slab_key_store_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the slab key store core
// Shared wrappers that clock on clk and hold off during reset.
// ----------------------------------------------------------------------------
`ifndef TTL_SLAB_KEY_STORE_CORE_DEFINES_SVH
`define TTL_SLAB_KEY_STORE_CORE_DEFINES_SVH

// Check a property at every edge outside reset.
`define TSKS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TSKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tsks_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab key store package
// Types, codes and helper functions for the slab key store core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsks_pkg;

    localparam int CLASS_COUNT  = 4;
    localparam int CLASS_W      = 2;
    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = 8;
    localparam int SLOT_W       = CLASS_W + IDX_W;
    localparam int SLOTS        = CLASS_COUNT * MAX_BLOCKS;
    localparam int HEADER_BYTES = 16;
    localparam int TIME_W       = 48;
    localparam int LEN_W        = 25;
    localparam int BYTES_W      = 26;
    localparam int BLOCKS_W     = 9;
    localparam int ENTRY_W      = 1 + TIME_W + LEN_W;

    localparam logic [31:0] MAX_TTL  = 32'd86400000;
    localparam logic [63:0] PRNG_SEED = 64'd123456789;

    // Register indexes of the configuration channel
    localparam logic [2:0] REG_CLASS_BYTES_0  = 3'd0;
    localparam logic [2:0] REG_CLASS_BYTES_1  = 3'd1;
    localparam logic [2:0] REG_CLASS_BYTES_2  = 3'd2;
    localparam logic [2:0] REG_CLASS_BYTES_3  = 3'd3;
    localparam logic [2:0] REG_CLASS_BLOCKS_0 = 3'd4;
    localparam logic [2:0] REG_CLASS_BLOCKS_1 = 3'd5;
    localparam logic [2:0] REG_CLASS_BLOCKS_2 = 3'd6;
    localparam logic [2:0] REG_CLASS_BLOCKS_3 = 3'd7;

    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_DEL    = 3'd2,
        CMD_EXISTS = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_TTL    = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_CLASS_FULL = 4'd3,
        ST_NO_PROBE   = 4'd4,
        ST_BAD_ID     = 4'd5,
        ST_NOT_FOUND  = 4'd6,
        ST_EXPIRED    = 4'd7,
        ST_BUF_SMALL  = 4'd8
    } status_t;

    typedef enum logic [7:0] {
        FSM_CLEAR = 8'b0000_0001,
        FSM_IDLE  = 8'b0000_0010,
        FSM_EVAL  = 8'b0000_0100,
        FSM_DRAW  = 8'b0000_1000,
        FSM_DIV   = 8'b0001_0000,
        FSM_RD    = 8'b0010_0000,
        FSM_CHK   = 8'b0100_0000,
        FSM_OUT   = 8'b1000_0000
    } fsm_t;

    typedef struct packed {
        logic                used;
        logic [TIME_W-1:0]   expiry;
        logic [LEN_W-1:0]    length;
    } entry_t;

    // Saturate a block count to the class capacity.
    function automatic logic [BLOCKS_W-1:0] blocks_sat(input logic [BLOCKS_W-1:0] b);
        logic [BLOCKS_W-1:0] cap;
        cap = BLOCKS_W'(MAX_BLOCKS);
        return (b > cap) ? cap : b;
    endfunction

    // One xorshift64 step.
    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

endpackage

// ===== rtl/ttl_slab_key_store_core.sv =====
// ----------------------------------------------------------------------------
// Slab key store core
// Block metadata for a size-class slab store with per-entry expiry.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                          | Direction | Contents
//  ---------+----------------------------------+-----------+------------------------
//  cmd in   | s_tvalid s_tready s_tdata s_tuser | in        | one command
//  result   | m_tvalid m_tready m_tdata        | out       | one result per command
//  config   | cfg_valid cfg_ready cfg_index    | in        | class size / count write
//           | cfg_data                         |           |
//
//  One command at a time. Tick, bad ttl and size/full rejects pass from capture
//  to evaluation and output; get/delete/exists add one registered entry read.
//  A set draws up to three random indexes, each reduced by the block count in
//  the 64-step remainder unit, and reads the drawn entry and, if used, the next.
//  After reset a clearing pass wipes the used bits; no command
//  is taken meanwhile, configuration writes are. A stalled result is held in
//  the output register while the next command is taken and worked on.
//
`timescale 1ns / 1ps
`include "ttl_slab_key_store_core_defines.svh"

module ttl_slab_key_store_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [24:0] value_length, [56:25] ttl_ms, [72:57] key_id, [98:73] buffer_size
    input  logic [103:0] s_tdata,
    // [2:0] cmd
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] status, [13:4] global_id, [38:14] stored_length, [39] present,
    // [50:40] active_keys
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [25:0]  cfg_data
);

    localparam int TW = tsks_pkg::TIME_W;
    localparam int LW = tsks_pkg::LEN_W;
    localparam int BW = tsks_pkg::BLOCKS_W;
    localparam int YW = tsks_pkg::BYTES_W;
    localparam int IW = tsks_pkg::IDX_W;
    localparam int CW = tsks_pkg::CLASS_W;
    localparam int NC = tsks_pkg::CLASS_COUNT;

    // Configuration
    logic [YW-1:0] cbytes_reg  [NC];
    logic [BW-1:0] cblocks_reg [NC];
    logic [BW-1:0] blk         [NC];

    // Control and counters
    tsks_pkg::fsm_t    state_reg, state_next;
    logic [tsks_pkg::SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [63:0]       prng_reg, prng_next;
    logic [TW-1:0]     now_reg, now_next;
    logic [10:0]       live_cnt_reg, live_cnt_next;
    logic [BW-1:0]     used_cnt_reg [NC];
    logic [BW-1:0]     used_cnt_next [NC];

    // Captured command
    tsks_pkg::cmd_t    cmd_reg, cmd_next;
    logic [LW-1:0]     vlen_reg, vlen_next;
    logic [31:0]       ttl_reg, ttl_next;
    logic [15:0]       key_reg, key_next;
    logic [YW-1:0]     buf_reg, buf_next;

    // Work registers
    logic [CW-1:0]     cls_reg, cls_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              probe_reg, probe_next;
    logic [1:0]        try_reg, try_next;
    logic [5:0]        div_cnt_reg, div_cnt_next;
    logic [63:0]       div_q_reg, div_q_next;
    logic [BW-1:0]     rem_reg, rem_next;

    // Result
    tsks_pkg::status_t res_status_reg, res_status_next;
    logic [9:0]        res_gid_reg, res_gid_next;
    logic [LW-1:0]     res_slen_reg, res_slen_next;
    logic              res_present_reg, res_present_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [55:0]       m_tdata_reg, m_tdata_next;

    // Entry memory
    tsks_pkg::entry_t  mem_array [tsks_pkg::SLOTS];
    tsks_pkg::entry_t  rd_data_reg;
    tsks_pkg::entry_t  mem_wd;
    logic              mem_we, mem_re;
    logic [tsks_pkg::SLOT_W-1:0] mem_wa, mem_ra;

    // Decode helpers
    logic [YW-1:0]     total_bytes;
    logic              cls_found;
    logic [CW-1:0]     cls_pick;
    logic [10:0]       offset;
    logic [10:0]       base;
    logic [15:0]       id_ext;
    logic              id_found;
    logic [CW-1:0]     id_cls;
    logic [IW-1:0]     id_idx;
    logic [BW:0]       div_trial;
    logic [BW-1:0]     div_rem;
    logic [BW-1:0]     idx_inc;
    logic              expired;
    logic [11:0]       used_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == tsks_pkg::FSM_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            blk[c] = tsks_pkg::blocks_sat(cblocks_reg[c]);
        end
    end

    // Configuration writes; they never touch stored entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbytes_reg[0]  <= YW'(64);
            cbytes_reg[1]  <= YW'(1024);
            cbytes_reg[2]  <= YW'(65536);
            cbytes_reg[3]  <= YW'(16777216);
            for (int c = 0; c < NC; c++)
            begin
                cblocks_reg[c] <= BW'(256);
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index < tsks_pkg::REG_CLASS_BLOCKS_0)
            begin
                cbytes_reg[cfg_index[1:0]] <= cfg_data;
            end
            else
            begin
                cblocks_reg[cfg_index[1:0]] <= cfg_data[BW-1:0];
            end
        end
    end

    // Combinational helpers: class pick, id decode, remainder step.
    always_comb
    begin
        total_bytes = YW'(tsks_pkg::HEADER_BYTES) + YW'(vlen_reg);
        cls_found   = 1'b0;
        cls_pick    = '0;
        for (int c = NC - 1; c >= 0; c--)
        begin
            if (total_bytes <= cbytes_reg[c])
            begin
                cls_found = 1'b1;
                cls_pick  = CW'(c);
            end
        end

        id_ext   = {1'b0, key_reg[14:0]};
        id_found = 1'b0;
        id_cls   = '0;
        id_idx   = '0;
        offset   = '0;
        for (int c = 0; c < NC; c++)
        begin
            if (!id_found && !key_reg[15] &&
                id_ext < (16'(offset) + 16'(blk[c])))
            begin
                id_found = 1'b1;
                id_cls   = CW'(c);
                id_idx   = IW'(id_ext - 16'(offset));
            end
            offset = offset + 11'(blk[c]);
        end

        base = '0;
        for (int c = 0; c < NC; c++)
        begin
            if (CW'(c) < cls_reg)
            begin
                base = base + 11'(blk[c]);
            end
        end

        div_trial = {rem_reg, div_q_reg[63]};
        if (div_trial >= {1'b0, blk[cls_reg]})
        begin
            div_rem = BW'(div_trial - {1'b0, blk[cls_reg]});
        end
        else
        begin
            div_rem = div_trial[BW-1:0];
        end

        idx_inc = BW'(idx_reg) + BW'(1);
        expired = (now_reg >= rd_data_reg.expiry);

        used_sum = '0;
        for (int c = 0; c < NC; c++)
        begin
            used_sum = used_sum + 12'(used_cnt_reg[c]);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        prng_next        = prng_reg;
        now_next         = now_reg;
        live_cnt_next    = live_cnt_reg;
        used_cnt_next    = used_cnt_reg;
        cmd_next         = cmd_reg;
        vlen_next        = vlen_reg;
        ttl_next         = ttl_reg;
        key_next         = key_reg;
        buf_next         = buf_reg;
        cls_next         = cls_reg;
        idx_next         = idx_reg;
        probe_next       = probe_reg;
        try_next         = try_reg;
        div_cnt_next     = div_cnt_reg;
        div_q_next       = div_q_reg;
        rem_next         = rem_reg;
        res_status_next  = res_status_reg;
        res_gid_next     = res_gid_reg;
        res_slen_next    = res_slen_reg;
        res_present_next = res_present_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        mem_wa           = {cls_reg, idx_reg};
        mem_wd           = rd_data_reg;
        mem_re           = 1'b0;
        mem_ra           = {cls_reg, idx_reg};

        case (state_reg)
            tsks_pkg::FSM_CLEAR:
            begin
                // Wipe one used bit per cycle.
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                mem_wd       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = tsks_pkg::FSM_IDLE;
                end
            end

            tsks_pkg::FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next         = tsks_pkg::cmd_t'(s_tuser);
                    vlen_next        = s_tdata[24:0];
                    ttl_next         = s_tdata[56:25];
                    key_next         = s_tdata[72:57];
                    buf_next         = s_tdata[98:73];
                    res_status_next  = tsks_pkg::ST_OK;
                    res_gid_next     = '0;
                    res_slen_next    = '0;
                    res_present_next = 1'b0;
                    state_next       = tsks_pkg::FSM_EVAL;
                end
            end

            tsks_pkg::FSM_EVAL:
            begin
                state_next = tsks_pkg::FSM_OUT;
                case (cmd_reg)
                    tsks_pkg::CMD_SET:
                    begin
                        if (ttl_reg == '0 || ttl_reg > tsks_pkg::MAX_TTL)
                        begin
                            res_status_next = tsks_pkg::ST_BAD_TTL;
                        end
                        else if (!cls_found)
                        begin
                            res_status_next = tsks_pkg::ST_TOO_LARGE;
                        end
                        else if (used_cnt_reg[cls_pick] >= blk[cls_pick])
                        begin
                            res_status_next = tsks_pkg::ST_CLASS_FULL;
                        end
                        else
                        begin
                            cls_next   = cls_pick;
                            try_next   = '0;
                            state_next = tsks_pkg::FSM_DRAW;
                        end
                    end
                    tsks_pkg::CMD_GET, tsks_pkg::CMD_DEL, tsks_pkg::CMD_EXISTS:
                    begin
                        if (!id_found)
                        begin
                            res_status_next = tsks_pkg::ST_BAD_ID;
                        end
                        else
                        begin
                            cls_next   = id_cls;
                            idx_next   = id_idx;
                            state_next = tsks_pkg::FSM_RD;
                        end
                    end
                    tsks_pkg::CMD_TICK:
                    begin
                        now_next = now_reg + 1'b1;
                    end
                    default:
                    begin
                        res_status_next = tsks_pkg::ST_OK;
                    end
                endcase
            end

            tsks_pkg::FSM_DRAW:
            begin
                // Advance the generator and start the remainder unit.
                prng_next    = tsks_pkg::xorshift(prng_reg);
                div_q_next   = tsks_pkg::xorshift(prng_reg);
                rem_next     = '0;
                div_cnt_next = '1;
                state_next   = tsks_pkg::FSM_DIV;
            end

            tsks_pkg::FSM_DIV:
            begin
                rem_next     = div_rem;
                div_q_next   = {div_q_reg[62:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    idx_next   = div_rem[IW-1:0];
                    probe_next = 1'b0;
                    state_next = tsks_pkg::FSM_RD;
                end
            end

            tsks_pkg::FSM_RD:
            begin
                mem_re     = 1'b1;
                state_next = tsks_pkg::FSM_CHK;
            end

            tsks_pkg::FSM_CHK:
            begin
                // Outside the clearing pass entries are rewritten here only; the next
                // read comes in a later cycle, so no forwarding is needed.
                state_next = tsks_pkg::FSM_OUT;
                if (cmd_reg == tsks_pkg::CMD_SET)
                begin
                    if (!rd_data_reg.used)
                    begin
                        mem_we                 = 1'b1;
                        mem_wd.used            = 1'b1;
                        mem_wd.expiry          = now_reg + TW'(ttl_reg);
                        mem_wd.length          = vlen_reg;
                        used_cnt_next[cls_reg] = used_cnt_reg[cls_reg] + 1'b1;
                        live_cnt_next          = live_cnt_reg + 1'b1;
                        res_gid_next           = 10'(base + 11'(idx_reg));
                        res_status_next        = tsks_pkg::ST_OK;
                    end
                    else if (!probe_reg)
                    begin
                        idx_next   = (idx_inc == blk[cls_reg]) ? '0 : idx_inc[IW-1:0];
                        probe_next = 1'b1;
                        state_next = tsks_pkg::FSM_RD;
                    end
                    else if (try_reg == 2'd2)
                    begin
                        res_status_next = tsks_pkg::ST_NO_PROBE;
                    end
                    else
                    begin
                        try_next   = try_reg + 1'b1;
                        state_next = tsks_pkg::FSM_DRAW;
                    end
                end
                else if (!rd_data_reg.used)
                begin
                    res_status_next = tsks_pkg::ST_NOT_FOUND;
                end
                else if (cmd_reg == tsks_pkg::CMD_DEL ||
                         (cmd_reg == tsks_pkg::CMD_GET && expired))
                begin
                    // Release the entry; counters saturate at zero.
                    mem_we      = 1'b1;
                    mem_wd.used = 1'b0;
                    if (used_cnt_reg[cls_reg] != '0)
                    begin
                        used_cnt_next[cls_reg] = used_cnt_reg[cls_reg] - 1'b1;
                    end
                    if (live_cnt_reg != '0)
                    begin
                        live_cnt_next = live_cnt_reg - 1'b1;
                    end
                    if (cmd_reg == tsks_pkg::CMD_GET)
                    begin
                        res_status_next = tsks_pkg::ST_EXPIRED;
                    end
                end
                else if (expired)
                begin
                    res_status_next = tsks_pkg::ST_EXPIRED;
                end
                else if (cmd_reg == tsks_pkg::CMD_GET)
                begin
                    if (YW'(rd_data_reg.length) >= buf_reg)
                    begin
                        res_status_next = tsks_pkg::ST_BUF_SMALL;
                    end
                    else
                    begin
                        res_slen_next = rd_data_reg.length;
                    end
                end
                else
                begin
                    res_present_next = 1'b1;
                end
            end

            tsks_pkg::FSM_OUT:
            begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, live_cnt_reg, res_present_reg,
                                     res_slen_reg, res_gid_reg, res_status_reg};
                    state_next    = tsks_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = tsks_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsks_pkg::FSM_CLEAR;
            clr_cnt_reg  <= '0;
            prng_reg     <= tsks_pkg::PRNG_SEED;
            now_reg      <= '0;
            live_cnt_reg <= '0;
            for (int c = 0; c < NC; c++)
            begin
                used_cnt_reg[c] <= '0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            prng_reg      <= prng_next;
            now_reg       <= now_next;
            live_cnt_reg  <= live_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload and work registers: no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        vlen_reg        <= vlen_next;
        ttl_reg         <= ttl_next;
        key_reg         <= key_next;
        buf_reg         <= buf_next;
        cls_reg         <= cls_next;
        idx_reg         <= idx_next;
        probe_reg       <= probe_next;
        try_reg         <= try_next;
        div_cnt_reg     <= div_cnt_next;
        div_q_reg       <= div_q_next;
        rem_reg         <= rem_next;
        res_status_reg  <= res_status_next;
        res_gid_reg     <= res_gid_next;
        res_slen_reg    <= res_slen_next;
        res_present_reg <= res_present_next;
        m_tdata_reg     <= m_tdata_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_array[mem_ra];
        end
    end

    `TSKS_ASSERT(a_live_bound, live_cnt_reg <= 11'd1024, "live count above capacity")
    `TSKS_ASSERT(a_count_sum, used_sum == {1'b0, live_cnt_reg}, "class counts disagree with live count")
    `TSKS_ASSERT(a_rem_range, (state_reg != tsks_pkg::FSM_DIV) || (rem_reg < blk[cls_reg]), "remainder out of range")
    `TSKS_ASSERT_NEXT(a_set_counts, (state_reg == tsks_pkg::FSM_CHK) && (cmd_reg == tsks_pkg::CMD_SET) && !rd_data_reg.used, live_cnt_reg == $past(live_cnt_reg) + 11'd1, "set did not count entry")

endmodule
